// ----- design/lcd_pkg.sv -----
`default_nettype none

package lcd_pkg;

	localparam int NumRows  = 8;
	localparam int NumCols  = 16;
	localparam int NumPairs = NumCols * (NumCols - 1) / 2;

	localparam logic ActEncode = 1'b0;
	localparam logic ActDecode = 1'b1;

	// Rows of the parity-check matrix; bit 15-j of a row holds column j.
	localparam logic [NumCols-1:0] HRows [NumRows] = '{
		16'hF380, 16'h0F40, 16'h5720, 16'hCA10,
		16'hA908, 16'h6D04, 16'h9B02, 16'hB501
	};

	typedef logic [NumRows-1:0]  syn_t;
	typedef logic [NumCols-1:0]  word_t;
	typedef logic [NumPairs-1:0] pairs_t;

	typedef struct packed {
		word_t  single;
		pairs_t pair;
	} match_t;

	// Column j of the matrix, laid out as a syndrome (bit 7-i from row i).
	function automatic syn_t h_col(input int j);
		syn_t c;
		c = '0;
		for (int i = 0; i < NumRows; i++) begin
			c[NumRows-1-i] = HRows[i][NumCols-1-j];
		end
		return c;
	endfunction

	function automatic syn_t syndrome(input word_t w);
		syn_t s;
		s = '0;
		for (int i = 0; i < NumRows; i++) begin
			s[NumRows-1-i] = ^(HRows[i] & w);
		end
		return s;
	endfunction

	// Position of pair (i, j), i < j, in ascending scan order.
	function automatic int pair_idx(input int i, input int j);
		return i * (NumCols - 1) - (i * (i - 1)) / 2 + (j - i - 1);
	endfunction

endpackage

`default_nettype wire

// ----- design/lcd_in_if.sv -----
`default_nettype none

interface lcd_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] data_in;

	modport source (output valid, output action, output data_in, input ready);
	modport sink   (input valid, input action, input data_in, output ready);
endinterface

`default_nettype wire

// ----- design/lcd_out_if.sv -----
`default_nettype none

interface lcd_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

// ----- design/lcd_match.sv -----
`default_nettype none

module lcd_match
	import lcd_pkg::*;
(
	input  syn_t   syn,
	output match_t match
);

	for (genvar j = 0; j < NumCols; j++) begin : g_single
		assign match.single[j] = (syn == h_col(j));
	end

	for (genvar i = 0; i < NumCols - 1; i++) begin : g_row
		for (genvar j = i + 1; j < NumCols; j++) begin : g_pair
			assign match.pair[pair_idx(i, j)] = (syn == (h_col(i) ^ h_col(j)));
		end
	end

endmodule

`default_nettype wire

// ----- design/linear_16_8_dec_codec_core.sv -----
// (16,8) linear block codec with double error correction.
// Input channel din carries action and data_in: with action low the byte in
// data_in[7:0] is encoded into a 16-bit codeword; with action high data_in is
// taken as a received word and the corrected byte is returned in bits 7..0.
// Output channel dout carries data_out, one item for every input item, in order.
// Both channels use valid/ready; an item moves when both are high.
// The pipeline has three register stages: syndrome, column and pair matching,
// then first-pair selection with the correction. An item accepted into the
// syndrome stage passes the match stage and then the output stage before it is
// valid on data_out; one item is taken every cycle while din.ready is high.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and din.ready falls in the same cycle, so nothing is lost or
// repeated. Reset clears the valid bits only; the block has no other state and
// needs no configuration.
`default_nettype none

module linear_16_8_dec_codec_core
	import lcd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lcd_in_if.sink    din,
	lcd_out_if.source dout
);

	logic   adv;
	logic   v_s1, v_s2, v_s3;
	logic   act_s1, act_s2, act_s3;
	word_t  word_s1, word_s2;
	syn_t   syn_s1, syn_s2;
	match_t match_c, match_s2;
	word_t  data_s3;
	word_t  word_in;
	pairs_t first_c;
	word_t  flip_c;
	word_t  fixed_c;

	assign adv       = !v_s3 || dout.ready;
	assign din.ready = adv;

	// Encoding computes the syndrome of the byte placed above zero parities.
	assign word_in = (din.action == ActDecode) ? din.data_in : {din.data_in[7:0], 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= din.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1   <= din.action;
			word_s1  <= word_in;
			syn_s1   <= syndrome(word_in);
			act_s2   <= act_s1;
			word_s2  <= word_s1;
			syn_s2   <= syn_s1;
			match_s2 <= match_c;
			act_s3   <= act_s2;
			data_s3  <= (act_s2 == ActDecode) ? {8'h00, fixed_c[15:8]}
			                                  : {word_s2[15:8], syn_s2};
		end
	end

	lcd_match u_match (
		.syn   (syn_s1),
		.match (match_c)
	);

	// Only the first matching pair in scan order is corrected.
	assign first_c = match_s2.pair & (~match_s2.pair + {{(NumPairs-1){1'b0}}, 1'b1});

	always_comb begin
		flip_c = '0;
		for (int j = 0; j < NumCols; j++) begin
			flip_c[NumCols-1-j] = match_s2.single[j];
		end
		for (int i = 0; i < NumCols - 1; i++) begin
			for (int j = i + 1; j < NumCols; j++) begin
				flip_c[NumCols-1-i] = flip_c[NumCols-1-i] ^ first_c[pair_idx(i, j)];
				flip_c[NumCols-1-j] = flip_c[NumCols-1-j] ^ first_c[pair_idx(i, j)];
			end
		end
	end

	assign fixed_c = word_s2 ^ flip_c;

	assign dout.valid    = v_s3;
	assign dout.data_out = data_s3;

	a_pair_once: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $onehot0(first_c))
		else $error("more than one pair selected for correction");

	a_zero_syn: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && syn_s2 == '0) |-> (match_s2.single == '0 && match_s2.pair == '0))
		else $error("zero syndrome produced a correction");

	a_dec_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && act_s3 == ActDecode) |-> (data_s3[15:8] == 8'h00))
		else $error("decoded item has non-zero upper byte");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> v_s2)
		else $error("item lost between syndrome and match stages");

endmodule

`default_nettype wire
